// File: rtl/buddy_page_allocator_top_assert.svh
// assertion macros for the allocator rtl, included by bpa_ctrl
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpa assertion failed");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpa assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int MAX_PAGES  = 65536;
   localparam int MAX_ORDER  = 10;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int LINK_W     = PAGE_W + 1;
   localparam int COUNT_W    = 17;
   localparam int ADDR_W     = 48;
   localparam int ORD_W      = 4;
   localparam int MAP_W      = 8;

   localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(MAX_PAGES);
   localparam logic [MAP_W-1:0]  ALLOCATED = 8'hFF;

   // item kinds
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // result codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_INIT  = 3'd1;
   localparam logic [2:0] ST_BAD_ORDER = 3'd2;
   localparam logic [2:0] ST_NO_MEM    = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   // register indexes
   localparam logic CSR_BASE   = 1'b0;
   localparam logic CSR_REGION = 1'b1;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] waddr;
      logic [MAP_W-1:0]  wdata;
      logic [PAGE_W-1:0] raddr;
   } map_port_type;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] waddr;
      logic [LINK_W-1:0] wdata;
      logic [PAGE_W-1:0] raddr;
   } link_port_type;
endpackage

// File: rtl/bpa_req_if.sv
`timescale 1ns / 1ps
interface bpa_req_if;
   import bpa_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [ORD_W-1:0]  order;
   logic [ADDR_W-1:0] address;
   modport source (output valid, mode, order, address, input ready);
   modport sink (input valid, mode, order, address, output ready);
endinterface

// File: rtl/bpa_rsp_if.sv
`timescale 1ns / 1ps
interface bpa_rsp_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [ADDR_W-1:0]  block_address;
   logic [COUNT_W-1:0] free_page_count;
   modport source (output valid, status, block_address, free_page_count, input ready);
   modport sink (input valid, status, block_address, free_page_count, output ready);
endinterface

// File: rtl/bpa_ram.sv
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int AW    = 16
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [0:(1<<AW)-1];
   logic [WIDTH-1:0] rdata_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
module bpa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   bpa_req_if.sink                       req,
   bpa_rsp_if.source                     rsp,
   input  logic [bpa_pkg::ADDR_W-1:0]    base_address,
   input  logic [bpa_pkg::COUNT_W-1:0]   region_pages,
   output bpa_pkg::map_port_type         map_port,
   output bpa_pkg::link_port_type        next_port,
   output bpa_pkg::link_port_type        prev_port,
   input  logic [bpa_pkg::MAP_W-1:0]     map_rd,
   input  logic [bpa_pkg::LINK_W-1:0]    next_rd,
   input  logic [bpa_pkg::LINK_W-1:0]    prev_rd
);
   import bpa_pkg::*;
   `include "buddy_page_allocator_top_assert.svh"

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLR    = 4'd1;
   localparam logic [3:0] S_SEED   = 4'd2;
   localparam logic [3:0] S_PUSH1  = 4'd3;
   localparam logic [3:0] S_PUSH2  = 4'd4;
   localparam logic [3:0] S_UNL1   = 4'd5;
   localparam logic [3:0] S_UNL2   = 4'd6;
   localparam logic [3:0] S_ALLOC  = 4'd7;
   localparam logic [3:0] S_SPLIT  = 4'd8;
   localparam logic [3:0] S_FREE0  = 4'd9;
   localparam logic [3:0] S_FREE1  = 4'd10;
   localparam logic [3:0] S_FLOOP  = 4'd11;
   localparam logic [3:0] S_FCHK   = 4'd12;
   localparam logic [3:0] S_FMERGE = 4'd13;
   localparam logic [3:0] S_FDONE  = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);

   // control state
   logic [3:0]         st_ff, st_in, ret_ff, ret_in;
   logic               ready_ff, ready_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [LINK_W-1:0]  head_ff [0:MAX_ORDER];
   logic [LINK_W-1:0]  head_in [0:MAX_ORDER];
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [ORD_W-1:0]   ord_ff, ord_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COUNT_W-1:0] pg_ff, pg_in;
   logic [ORD_W-1:0]   seed_ord_ff, seed_ord_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic [ORD_W-1:0]   cur_ff, cur_in;
   logic [PAGE_W-1:0]  tgt_ff, tgt_in;
   logic [ORD_W-1:0]   tord_ff, tord_in;
   logic [LINK_W-1:0]  old_head_ff, old_head_in;
   logic [2:0]         stat_ff, stat_in;
   logic [ADDR_W-1:0]  blk_ff, blk_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // helpers
   logic               avail_found;
   logic [ORD_W-1:0]   avail_ord;
   logic [ORD_W-1:0]   head_idx;
   logic [LINK_W-1:0]  head_rd;
   logic [COUNT_W-1:0] seed_blk, seed_a, seed_end;
   logic               seed_fit;
   logic [ADDR_W-1:0]  off;
   logic [ADDR_W-PAGE_SHIFT-1:0] pidx;
   logic [PAGE_W-1:0]  ord_blk;
   logic               free_bad;
   logic [PAGE_W-1:0]  bud;
   logic [PAGE_W-1:0]  cur_bit;
   logic               rsp_load;

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

   // smallest non-empty order at or above the request
   always_comb begin
      avail_found = 1'b0;
      avail_ord   = '0;
      for (int i = MAX_ORDER; i >= 0; i--) begin
         if (!head_ff[i][PAGE_W] && ORD_W'(i) >= ord_ff) begin
            avail_found = 1'b1;
            avail_ord   = ORD_W'(i);
         end
      end
   end

   // single read port on the list heads
   assign head_idx = (st_ff == S_ALLOC) ? avail_ord : tord_ff;
   assign head_rd  = head_ff[head_idx];

   // seeding position for the current order
   assign seed_blk = COUNT_W'(1) << seed_ord_ff;
   assign seed_a   = (pg_ff + seed_blk - COUNT_W'(1)) & ~(seed_blk - COUNT_W'(1));
   assign seed_end = seed_a + seed_blk;
   assign seed_fit = (pg_ff < total_ff) && (seed_end <= total_ff);

   // free address checks
   assign off      = addr_ff - base_address;
   assign pidx     = off[ADDR_W-1:PAGE_SHIFT];
   assign ord_blk  = PAGE_W'(1) << ord_ff;
   assign free_bad = (pidx >= (ADDR_W-PAGE_SHIFT)'(total_ff))
                     || ((pidx[PAGE_W-1:0] & (ord_blk - PAGE_W'(1))) != '0)
                     || ((pidx[COUNT_W-1:0] + COUNT_W'(ord_blk)) > total_ff);

   assign cur_bit = PAGE_W'(1) << cur_ff;
   assign bud     = idx_ff ^ cur_bit;

   // response register takes a result this cycle
   assign rsp_load = (st_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   // sequencer
   always_comb begin
      st_in         = st_ff;
      ret_in        = ret_ff;
      ready_in      = ready_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff;
      ord_in        = ord_ff;
      addr_in       = addr_ff;
      pg_in         = pg_ff;
      seed_ord_in   = seed_ord_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      tord_in       = tord_ff;
      old_head_in   = old_head_ff;
      stat_in       = stat_ff;
      blk_in        = blk_ff;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_count_in  = rsp_count_ff;

      map_port        = '0;
      map_port.waddr  = tgt_ff;
      map_port.raddr  = tgt_ff;
      next_port       = '0;
      next_port.waddr = tgt_ff;
      next_port.raddr = tgt_ff;
      prev_port       = '0;
      prev_port.waddr = tgt_ff;
      prev_port.raddr = tgt_ff;

      // output register drains independently
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               ord_in  = req.order;
               addr_in = req.address;
               stat_in = ST_OK;
               blk_in  = '0;
               case (req.mode)
                  MODE_INIT: begin
                     if (region_pages > COUNT_W'(MAX_PAGES)) begin
                        total_in = COUNT_W'(MAX_PAGES);
                     end else begin
                        total_in = region_pages;
                     end
                     free_in  = '0;
                     ready_in = 1'b0;
                     for (int i = 0; i <= MAX_ORDER; i++) begin
                        head_in[i] = NO_LINK;
                     end
                     pg_in = '0;
                     st_in = S_CLR;
                  end
                  MODE_ALLOC, MODE_FREE: begin
                     if (!ready_ff) begin
                        stat_in = ST_NOT_INIT;
                        st_in   = S_DONE;
                     end else if (req.order > MAX_ORD) begin
                        stat_in = ST_BAD_ORDER;
                        st_in   = S_DONE;
                     end else if (req.mode == MODE_ALLOC) begin
                        st_in = S_ALLOC;
                     end else begin
                        st_in = S_FREE0;
                     end
                  end
                  default: begin
                     st_in = S_DONE;
                  end
               endcase
            end
         end
         // mark every page allocated
         S_CLR: begin
            if (pg_ff == total_ff) begin
               pg_in       = COUNT_W'(({1'b0, total_ff} + (COUNT_W+1)'(PAGE_BYTES - 1))
                                      >> PAGE_SHIFT);
               seed_ord_in = MAX_ORD;
               st_in       = S_SEED;
            end else begin
               map_port.we    = 1'b1;
               map_port.waddr = pg_ff[PAGE_W-1:0];
               map_port.wdata = ALLOCATED;
               pg_in          = pg_ff + COUNT_W'(1);
            end
         end
         // place aligned blocks from the running position
         S_SEED: begin
            if (seed_fit) begin
               tgt_in  = seed_a[PAGE_W-1:0];
               tord_in = seed_ord_ff;
               pg_in   = seed_end;
               free_in = sat_add(free_ff, seed_blk);
               ret_in  = S_SEED;
               st_in   = S_PUSH1;
            end else if (pg_ff >= total_ff || seed_ord_ff == '0) begin
               ready_in = 1'b1;
               st_in    = S_DONE;
            end else begin
               seed_ord_in = seed_ord_ff - ORD_W'(1);
            end
         end
         // push tgt onto list tord
         S_PUSH1: begin
            map_port.we    = 1'b1;
            map_port.wdata = MAP_W'(tord_ff);
            next_port.we    = 1'b1;
            next_port.wdata = head_rd;
            prev_port.we    = 1'b1;
            prev_port.wdata = NO_LINK;
            old_head_in     = head_rd;
            head_in[tord_ff] = LINK_W'(tgt_ff);
            st_in = S_PUSH2;
         end
         S_PUSH2: begin
            if (old_head_ff != NO_LINK) begin
               prev_port.we    = 1'b1;
               prev_port.waddr = old_head_ff[PAGE_W-1:0];
               prev_port.wdata = LINK_W'(tgt_ff);
            end
            st_in = ret_ff;
         end
         // unlink tgt from list tord
         S_UNL1: begin
            st_in = S_UNL2;
         end
         S_UNL2: begin
            if (prev_rd != NO_LINK) begin
               next_port.we    = 1'b1;
               next_port.waddr = prev_rd[PAGE_W-1:0];
               next_port.wdata = next_rd;
            end else begin
               head_in[tord_ff] = next_rd;
            end
            if (next_rd != NO_LINK) begin
               prev_port.we    = 1'b1;
               prev_port.waddr = next_rd[PAGE_W-1:0];
               prev_port.wdata = prev_rd;
            end
            map_port.we    = 1'b1;
            map_port.wdata = ALLOCATED;
            st_in = ret_ff;
         end
         S_ALLOC: begin
            if (!avail_found) begin
               stat_in = ST_NO_MEM;
               st_in   = S_DONE;
            end else begin
               cur_in  = avail_ord;
               idx_in  = head_rd[PAGE_W-1:0];
               tgt_in  = head_rd[PAGE_W-1:0];
               tord_in = avail_ord;
               ret_in  = S_SPLIT;
               st_in   = S_UNL1;
            end
         end
         // push upper halves down to the requested order
         S_SPLIT: begin
            if (cur_ff > ord_ff) begin
               cur_in  = cur_ff - ORD_W'(1);
               tord_in = cur_ff - ORD_W'(1);
               tgt_in  = idx_ff + (PAGE_W'(1) << (cur_ff - ORD_W'(1)));
               ret_in  = S_SPLIT;
               st_in   = S_PUSH1;
            end else begin
               if (COUNT_W'(ord_blk) >= free_ff) begin
                  free_in = '0;
               end else begin
                  free_in = free_ff - COUNT_W'(ord_blk);
               end
               blk_in = base_address + (ADDR_W'(idx_ff) << PAGE_SHIFT);
               st_in  = S_DONE;
            end
         end
         S_FREE0: begin
            map_port.raddr = pidx[PAGE_W-1:0];
            idx_in = pidx[PAGE_W-1:0];
            cur_in = ord_ff;
            if (free_bad) begin
               stat_in = ST_RANGE;
               st_in   = S_DONE;
            end else begin
               st_in = S_FREE1;
            end
         end
         S_FREE1: begin
            if (map_rd != ALLOCATED) begin
               stat_in = ST_RANGE;
               st_in   = S_DONE;
            end else begin
               st_in = S_FLOOP;
            end
         end
         // coalesce while the buddy is free at this order
         S_FLOOP: begin
            if (cur_ff < MAX_ORD && COUNT_W'(bud) < total_ff) begin
               map_port.raddr = bud;
               tgt_in = bud;
               st_in  = S_FCHK;
            end else begin
               tgt_in  = idx_ff;
               tord_in = cur_ff;
               ret_in  = S_FDONE;
               st_in   = S_PUSH1;
            end
         end
         S_FCHK: begin
            if (map_rd == MAP_W'(cur_ff)) begin
               tord_in = cur_ff;
               ret_in  = S_FMERGE;
               st_in   = S_UNL1;
            end else begin
               tgt_in  = idx_ff;
               tord_in = cur_ff;
               ret_in  = S_FDONE;
               st_in   = S_PUSH1;
            end
         end
         S_FMERGE: begin
            idx_in = idx_ff & ~cur_bit;
            cur_in = cur_ff + ORD_W'(1);
            st_in  = S_FLOOP;
         end
         S_FDONE: begin
            free_in = sat_add(free_ff, COUNT_W'(ord_blk));
            st_in   = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_block_in  = blk_ff;
               rsp_count_in  = free_ff;
               st_in         = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         ret_ff       <= S_IDLE;
         ready_ff     <= 1'b0;
         total_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= MAX_ORDER; i++) begin
            head_ff[i] <= NO_LINK;
         end
      end else begin
         st_ff        <= st_in;
         ret_ff       <= ret_in;
         ready_ff     <= ready_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      addr_ff       <= addr_in;
      pg_ff         <= pg_in;
      seed_ord_ff   <= seed_ord_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      tord_ff       <= tord_in;
      old_head_ff   <= old_head_in;
      stat_ff       <= stat_in;
      blk_ff        <= blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req.ready           = (st_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.block_address   = rsp_block_ff;
   assign rsp.free_page_count = rsp_count_ff;

   `BPA_ASSERT_NXT(a_accept_leaves_idle, req.valid && req.ready, st_ff != S_IDLE)
   `BPA_ASSERT_IMP(a_map_write_in_region, map_port.we, COUNT_W'(map_port.waddr) < total_ff)
   `BPA_ASSERT_IMP(a_unlink_list_live, st_ff == S_UNL2, head_rd != NO_LINK)
   `BPA_ASSERT_NXT(a_done_loads_rsp, rsp_load, rsp_valid_ff && (st_ff == S_IDLE))
endmodule

// File: rtl/buddy_page_allocator_top.sv
`timescale 1ns / 1ps
// Binary buddy page allocator over up to 65536 pages of 4 KiB. Each request
// beat is init, alloc, free or nop and yields one response beat with a status,
// the allocated block address and the free page count. Items are handled
// one at a time by a sequencer around three single-port-write page tables
// (order map, next and prev links), each with a registered read. Init
// marks the order map allocated, then seeds aligned blocks from the top
// order down; alloc unlinks a block and pushes the split halves back, and
// free merges the block with free buddies before pushing it. The request
// side is ready again while a finished response still waits in the output
// register.
module buddy_page_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   bpa_req_if.sink                     req,
   bpa_rsp_if.source                   rsp,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]  csr_write_data
);
   import bpa_pkg::*;

   logic [ADDR_W-1:0]  base_ff;
   logic [COUNT_W-1:0] region_ff;
   map_port_type       map_port;
   link_port_type      next_port, prev_port;
   logic [MAP_W-1:0]   map_rd;
   logic [LINK_W-1:0]  next_rd, prev_rd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         region_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE:   base_ff   <= csr_write_data;
            CSR_REGION: region_ff <= csr_write_data[COUNT_W-1:0];
            default:    base_ff   <= base_ff;
         endcase
      end
   end

   bpa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .base_address (base_ff),
      .region_pages (region_ff),
      .map_port     (map_port),
      .next_port    (next_port),
      .prev_port    (prev_port),
      .map_rd       (map_rd),
      .next_rd      (next_rd),
      .prev_rd      (prev_rd)
   );

   // order map per page
   bpa_ram #(.WIDTH(MAP_W), .AW(PAGE_W)) u_map (
      .clock (clock),
      .we    (map_port.we),
      .waddr (map_port.waddr),
      .wdata (map_port.wdata),
      .raddr (map_port.raddr),
      .rdata (map_rd)
   );

   // forward links of the free lists
   bpa_ram #(.WIDTH(LINK_W), .AW(PAGE_W)) u_next (
      .clock (clock),
      .we    (next_port.we),
      .waddr (next_port.waddr),
      .wdata (next_port.wdata),
      .raddr (next_port.raddr),
      .rdata (next_rd)
   );

   // backward links of the free lists
   bpa_ram #(.WIDTH(LINK_W), .AW(PAGE_W)) u_prev (
      .clock (clock),
      .we    (prev_port.we),
      .waddr (prev_port.waddr),
      .wdata (prev_port.wdata),
      .raddr (prev_port.raddr),
      .rdata (prev_rd)
   );
endmodule

// File: dv/bpa_checker.sv
`timescale 1ns / 1ps
module bpa_checker (
   input  logic                       clock,
   input  logic                       reset,
   bpa_req_if                         req,
   bpa_rsp_if                         rsp,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0] csr_write_data,
   output int                         fail_count,
   output int                         response_count
);
   import bpa_pkg::*;

   typedef struct packed {
      logic [2:0]         status;
      logic [ADDR_W-1:0]  block_address;
      logic [COUNT_W-1:0] free_page_count;
   } alloc_outcome_type;

   // mirror of the allocator state
   logic [MAP_W-1:0]   page_map [MAX_PAGES];
   logic [LINK_W-1:0]  fwd_link [MAX_PAGES];
   logic [LINK_W-1:0]  back_link [MAX_PAGES];
   logic [LINK_W-1:0]  free_head [16];
   logic [COUNT_W-1:0] free_len [16];
   longint             pages_free;
   bit                 initialized;
   longint             managed_pages;
   logic [ADDR_W-1:0]  region_base;
   logic [COUNT_W-1:0] region_size;

   alloc_outcome_type outcome_q [$];

   function automatic void clear_state();
      for (int i = 0; i < MAX_PAGES; i++) begin
         page_map[i]  = '0;
         fwd_link[i]  = '0;
         back_link[i] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         free_head[i] = NO_LINK;
         free_len[i]  = '0;
      end
      pages_free    = 0;
      initialized   = 0;
      managed_pages = 0;
      region_base   = '0;
      region_size   = '0;
   endfunction

   function automatic void grow_free(longint n);
      pages_free = (pages_free + n > 131071) ? 131071 : pages_free + n;
   endfunction

   function automatic void link_block(int ord, longint idx);
      logic [LINK_W-1:0] h;
      if (idx >= MAX_PAGES) return;
      h = free_head[ord];
      fwd_link[idx]  = h;
      back_link[idx] = NO_LINK;
      if (h < NO_LINK) back_link[h[PAGE_W-1:0]] = LINK_W'(idx);
      free_head[ord] = LINK_W'(idx);
      free_len[ord]  = free_len[ord] + 1'b1;
      page_map[idx]  = MAP_W'(ord);
   endfunction

   function automatic void drop_block(int ord, longint idx);
      logic [LINK_W-1:0] n;
      logic [LINK_W-1:0] p;
      if (idx >= MAX_PAGES) return;
      n = fwd_link[idx];
      p = back_link[idx];
      if (p < NO_LINK) fwd_link[p[PAGE_W-1:0]] = n;
      else free_head[ord] = n;
      if (n < NO_LINK) back_link[n[PAGE_W-1:0]] = p;
      free_len[ord] = free_len[ord] - 1'b1;
      page_map[idx] = ALLOCATED;
   endfunction

   // lay out the region and seed the free lists from the top order down
   function automatic void seed_region();
      longint total, pos, blk, a;
      total = (region_size > MAX_PAGES) ? MAX_PAGES : region_size;
      managed_pages = total;
      pages_free = 0;
      for (int i = 0; i < 16; i++) begin
         free_head[i] = NO_LINK;
         free_len[i]  = '0;
      end
      for (longint i = 0; i < total; i++) page_map[i] = ALLOCATED;
      pos = (total + PAGE_BYTES - 1) / PAGE_BYTES;
      for (int ord = MAX_ORDER; ord >= 0 && pos < total; ord--) begin
         blk = longint'(1) << ord;
         a = (pos + blk - 1) & ~(blk - 1);
         while (a + blk <= total) begin
            link_block(ord, a);
            grow_free(blk);
            a += blk;
            pos = a;
         end
      end
      initialized = 1;
   endfunction

   function automatic alloc_outcome_type predict_beat(logic [1:0] mode, logic [3:0] ord,
                                                      logic [ADDR_W-1:0] addr);
      alloc_outcome_type res;
      int avail, k;
      longint idx, blk, bud;
      logic [ADDR_W-1:0] offset;
      res = '0;
      if (mode == MODE_INIT) begin
         seed_region();
      end else if (mode == MODE_ALLOC || mode == MODE_FREE) begin
         if (!initialized) begin
            res.status = ST_NOT_INIT;
         end else if (ord > MAX_ORDER) begin
            res.status = ST_BAD_ORDER;
         end else if (mode == MODE_ALLOC) begin
            avail = ord;
            while (avail <= MAX_ORDER && free_head[avail] >= NO_LINK) avail++;
            if (avail > MAX_ORDER) begin
               res.status = ST_NO_MEM;
            end else begin
               idx = free_head[avail];
               drop_block(avail, idx);
               // split down, upper halves go back on the lists
               while (avail > ord) begin
                  avail--;
                  link_block(avail, idx + (longint'(1) << avail));
               end
               blk = longint'(1) << ord;
               pages_free = (blk >= pages_free) ? 0 : pages_free - blk;
               res.block_address = region_base + ADDR_W'(idx * PAGE_BYTES);
            end
         end else begin
            blk = longint'(1) << ord;
            offset = addr - region_base;
            idx = longint'(offset[ADDR_W-1:PAGE_SHIFT]);
            if (idx >= managed_pages || (idx & (blk - 1)) != 0 ||
                idx + blk > managed_pages || page_map[idx] != ALLOCATED) begin
               res.status = ST_RANGE;
            end else begin
               // merge with the buddy while it is a free block of this order
               k = ord;
               while (k < MAX_ORDER) begin
                  bud = idx ^ (longint'(1) << k);
                  if (!(bud < managed_pages && page_map[bud] == MAP_W'(k))) break;
                  drop_block(k, bud);
                  if (bud < idx) idx = bud;
                  k++;
               end
               link_block(k, idx);
               grow_free(blk);
            end
         end
      end
      res.free_page_count = COUNT_W'(pages_free);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      alloc_outcome_type want;
      int errs;
      errs = 0;
      if (reset) begin
         clear_state();
         outcome_q.delete();
         fail_count     <= 0;
         response_count <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_BASE) region_base = csr_write_data;
            else region_size = csr_write_data[COUNT_W-1:0];
         end
         if (req.valid && req.ready)
            outcome_q.push_back(predict_beat(req.mode, req.order, req.address));
         if (rsp.valid && rsp.ready) begin
            if (outcome_q.size() == 0) begin
               $error("response beat with nothing expected");
               errs++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errs++;
               end
               if (rsp.block_address !== want.block_address) begin
                  $error("block_address: expected %h, got %h",
                         want.block_address, rsp.block_address);
                  errs++;
               end
               if (rsp.free_page_count !== want.free_page_count) begin
                  $error("free_page_count: expected %0d, got %0d",
                         want.free_page_count, rsp.free_page_count);
                  errs++;
               end
            end
            response_count <= response_count + 1;
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import bpa_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_write_data;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   int fail_count;
   int response_count;
   int beats_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_asks;
   longint region_now;
   logic [ADDR_W-1:0] base_now;

   buddy_page_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if.sink),
      .rsp              (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bpa_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .response_count   (response_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // response side: random stalls plus one long hold-off
   always @(posedge clock) begin : receiver
      int hold_left;
      int hold_taken;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         hold_taken = 0;
      end else begin
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb NOT OK");
      $finish;
   end

   task automatic send_beat(input logic [1:0] mode, input logic [3:0] ord,
                            input logic [ADDR_W-1:0] addr);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.mode    <= mode;
      req_if.order   <= ord;
      req_if.address <= addr;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (response_count != beats_sent) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(input logic [ADDR_W-1:0] base, input longint pages);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BASE;
      csr_write_data   <= base;
      @(posedge clock);
      csr_index        <= CSR_REGION;
      csr_write_data   <= ADDR_W'(pages);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      base_now   = base;
      region_now = (pages > MAX_PAGES) ? MAX_PAGES : pages;
   endtask

   function automatic logic [ADDR_W-1:0] page_addr(longint idx, bit with_offset);
      logic [ADDR_W-1:0] a;
      a = base_now + ADDR_W'(idx * PAGE_BYTES);
      if (with_offset) a = a + ADDR_W'($urandom_range(PAGE_BYTES - 1));
      return a;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   // one random beat, mostly well-formed alloc and free traffic
   task automatic random_beat();
      int pick;
      logic [3:0] ord;
      longint idx;
      pick = $urandom_range(99);
      if (pick < 2) begin
         send_beat(MODE_INIT, 4'($urandom()), rand_addr());
      end else if (pick < 7) begin
         send_beat(2'($urandom_range(1, 3)), 4'($urandom()), rand_addr());
      end else if (pick < 55) begin
         ord = ($urandom_range(9) == 0) ? 4'($urandom_range(MAX_ORDER))
                                          : 4'($urandom_range(3));
         send_beat(MODE_ALLOC, ord, rand_addr());
      end else begin
         ord = ($urandom_range(9) == 0) ? 4'($urandom_range(MAX_ORDER))
                                          : 4'($urandom_range(3));
         idx = $urandom_range(0, int'(region_now) + 2);
         idx = idx & ~((longint'(1) << ord) - 1);
         send_beat(MODE_FREE, ord, page_addr(idx, $urandom_range(3) == 0));
      end
   endtask

   initial begin : stimulus
      longint regions [12] = '{1, 3, 16, 20, 64, 100, 256, 513, 1024, 4097, 65536, 40};
      logic [ADDR_W-1:0] base;
      int count;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.mode        = MODE_NOP;
      req_if.order       = '0;
      req_if.address     = '0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_BASE;
      csr_write_data     = '0;
      beats_sent         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_asks          = 0;
      region_now         = 0;
      base_now           = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // before init, then an empty region
      send_beat(MODE_ALLOC, 4'd0, '0);
      send_beat(MODE_FREE, 4'd0, '0);
      send_beat(MODE_NOP, 4'd15, {ADDR_W{1'b1}});
      send_beat(MODE_INIT, 4'd15, '0);
      send_beat(MODE_ALLOC, 4'd0, '0);
      drain();

      // region at the top of the address space so free addresses wrap
      write_regs({{(ADDR_W-PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}}, 20);
      send_beat(MODE_INIT, 4'd0, '0);
      send_beat(MODE_ALLOC, 4'd11, '0);
      send_beat(MODE_FREE, 4'd15, '0);
      send_beat(MODE_ALLOC, 4'd10, '0);
      send_beat(MODE_ALLOC, 4'd0, '0);
      send_beat(MODE_ALLOC, 4'd2, '0);
      send_beat(MODE_FREE, 4'd0, page_addr(8, 1));
      send_beat(MODE_FREE, 4'd0, page_addr(8, 0));
      send_beat(MODE_FREE, 4'd1, page_addr(9, 0));
      send_beat(MODE_FREE, 4'd0, page_addr(25, 0));
      send_beat(MODE_FREE, 4'd2, page_addr(16, 0));
      send_beat(MODE_FREE, 4'd2, page_addr(18, 0));
      send_beat(MODE_FREE, 4'd3, page_addr(16, 0));
      send_beat(MODE_FREE, 4'd0, page_addr(0, 0));
      send_beat(MODE_NOP, 4'd0, '0);
      drain();

      // random phases across region sizes and idle profiles
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         case (ph % 3)
            0: base = '0;
            1: base = {ADDR_W{1'b1}} << PAGE_SHIFT;
            default: base = rand_addr();
         endcase
         write_regs(base, regions[ph]);
         send_beat(MODE_INIT, 4'($urandom()), rand_addr());
         if (ph == 4) hold_asks++;
         count = (regions[ph] >= 4096) ? 40 : 120;
         repeat (count) random_beat();
         drain();
      end

      // register extreme past the clamp, then random traffic on it
      write_regs({ADDR_W{1'b1}}, 131071);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_beat(MODE_INIT, 4'd0, '0);
      repeat (8) random_beat();
      drain();

      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_req_if.sv
rtl/bpa_rsp_if.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator_top.sv
dv/bpa_checker.sv
dv/tb.sv
